// ----- hdl/rasmr_pkg.sv -----
package rasmr_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W = 34;
    localparam int DEN_W = 32;
    // working width for magnitudes (sum of two products)
    localparam int MAG_W = 2 * OPERAND_WIDTH + 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;

    typedef struct packed {
        logic [1:0]               func;
        logic [OPERAND_WIDTH-1:0] a_num;
        logic [OPERAND_WIDTH-1:0] a_den;
        logic [OPERAND_WIDTH-1:0] b_num;
        logic [OPERAND_WIDTH-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    div_zero;
    } rsp_t;

endpackage

// ----- hdl/rational_add_sub_mul_reduce_unit.sv -----
// Channel   | Signals                   | Handshake
// request   | start, busy, req          | taken when start && !busy
// result    | done, rsp                 | one-cycle strobe on done
//
// One shared bit-serial unit does the products, remainders and quotients:
// shift-add products, Euclid remainders by restoring division, then two
// quotient divisions. Multiply forms two products, add and subtract three;
// a zero result skips gcd and quotients.
// busy drops in the done cycle. rst_n clears control state asynchronously.
// The receiver cannot stall; done flags each result for one cycle.
module rational_add_sub_mul_reduce_unit
    import rasmr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_GSWAP, S_DNUM, S_DDEN, S_OUT
    } state_t;

    state_t state_reg;
    logic [MAG_W-1:0] acc_reg;      // product accumulator / remainder
    logic [MAG_W-1:0] mcand_reg;    // multiplicand / divisor
    logic [MAG_W-1:0] mplr_reg;     // multiplier / dividend shift register
    logic [MAG_W-1:0] p_reg, mag_reg, den_reg, x_reg, y_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg, dz_reg, done_reg;
    logic             step_reg;     // which product (0 first, 1 second)
    req_t             rq_reg;
    rsp_t             rsp_reg;

    // one restoring-division step: shift dividend bit into remainder
    logic [MAG_W:0]   rem_sh;
    logic [MAG_W:0]   rem_sub;
    assign rem_sh  = {acc_reg, mplr_reg[MAG_W-1]};
    assign rem_sub = rem_sh - {1'b0, mcand_reg};

    // one shift-add multiply step
    logic [MAG_W-1:0] mul_add;
    assign mul_add = mplr_reg[0] ? acc_reg + mcand_reg : acc_reg;

    logic [MAG_W-1:0] ext_an, ext_ad, ext_bn, ext_bd;
    assign ext_an = MAG_W'(rq_reg.a_num);
    assign ext_ad = MAG_W'(rq_reg.a_den);
    assign ext_bn = MAG_W'(rq_reg.b_num);
    assign ext_bd = MAG_W'(rq_reg.b_den);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rq_reg  <= req;
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        // denominator product first
                        mcand_reg <= MAG_W'(req.a_den);
                        mplr_reg  <= MAG_W'(req.b_den);
                        step_reg  <= 1'b0;
                        state_reg <= S_MUL1;
                    end
                end
                // den = ad*bd
                S_MUL1:
                begin
                    acc_reg   <= mul_add << 0;
                    mcand_reg <= mcand_reg << 1;
                    mplr_reg  <= mplr_reg >> 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST)
                    begin
                        den_reg <= mul_add;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        step_reg <= 1'b0;
                        if (rq_reg.func[1])
                        begin
                            mcand_reg <= ext_an;
                            mplr_reg  <= ext_bn;
                        end
                        else
                        begin
                            mcand_reg <= ext_an;
                            mplr_reg  <= ext_bd;
                        end
                        state_reg <= S_MUL2;
                    end
                end
                // numerator products
                S_MUL2:
                begin
                    acc_reg   <= mul_add;
                    mcand_reg <= mcand_reg << 1;
                    mplr_reg  <= mplr_reg >> 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        if (rq_reg.func[1] || step_reg)
                        begin
                            if (step_reg)
                                p_reg <= p_reg;
                            mag_reg   <= mul_add;
                            state_reg <= S_COMB;
                        end
                        else
                        begin
                            p_reg     <= mul_add;
                            step_reg  <= 1'b1;
                            mcand_reg <= ext_ad;
                            mplr_reg  <= ext_bn;
                        end
                    end
                end
                // combine p and q, check special cases
                S_COMB:
                begin
                    neg_reg <= 1'b0;
                    dz_reg  <= 1'b0;
                    if (!rq_reg.func[1])
                    begin
                        if (rq_reg.func == FUNC_ADD)
                            mag_reg <= p_reg + mag_reg;
                        else if (p_reg >= mag_reg)
                            mag_reg <= p_reg - mag_reg;
                        else
                        begin
                            mag_reg <= mag_reg - p_reg;
                            neg_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_GSWAP;
                    if (rq_reg.a_den == '0 || rq_reg.b_den == '0)
                    begin
                        dz_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    x_reg <= '0;
                    y_reg <= '0;
                end
                // load / advance Euclid pair; y==0 ends
                S_GSWAP:
                begin
                    if (x_reg == '0 && y_reg == '0)
                    begin
                        if (mag_reg == '0)
                            state_reg <= S_OUT;
                        else
                        begin
                            x_reg <= mag_reg;
                            y_reg <= den_reg;
                        end
                    end
                    else if (y_reg == '0)
                    begin
                        acc_reg   <= '0;
                        mplr_reg  <= mag_reg;
                        mcand_reg <= x_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_DNUM;
                    end
                    else
                    begin
                        acc_reg   <= '0;
                        mplr_reg  <= x_reg;
                        mcand_reg <= y_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_GCD;
                    end
                end
                // x mod y, bit-serial
                S_GCD:
                begin
                    mplr_reg <= mplr_reg << 1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    acc_reg  <= rem_sub[MAG_W] ? rem_sh[MAG_W-1:0]
                                               : rem_sub[MAG_W-1:0];
                    if (cnt_reg == LAST)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= rem_sub[MAG_W] ? rem_sh[MAG_W-1:0]
                                                    : rem_sub[MAG_W-1:0];
                        state_reg <= S_GSWAP;
                    end
                end
                // quotients: shifted-in bits build the quotient
                S_DNUM, S_DDEN:
                begin
                    mplr_reg <= {mplr_reg[MAG_W-2:0], ~rem_sub[MAG_W]};
                    cnt_reg  <= cnt_reg + 1'b1;
                    acc_reg  <= rem_sub[MAG_W] ? rem_sh[MAG_W-1:0]
                                               : rem_sub[MAG_W-1:0];
                    if (cnt_reg == LAST)
                    begin
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        if (state_reg == S_DNUM)
                        begin
                            mag_reg   <= {mplr_reg[MAG_W-2:0], ~rem_sub[MAG_W]};
                            mplr_reg  <= den_reg;
                            state_reg <= S_DDEN;
                        end
                        else
                        begin
                            den_reg   <= {mplr_reg[MAG_W-2:0], ~rem_sub[MAG_W]};
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    rsp_reg.div_zero <= dz_reg;
                    if (dz_reg || mag_reg == '0)
                    begin
                        rsp_reg.res_num <= '0;
                        rsp_reg.res_den <= DEN_W'(1);
                    end
                    else
                    begin
                        rsp_reg.res_num <= neg_reg ? -NUM_W'(mag_reg) : NUM_W'(mag_reg);
                        rsp_reg.res_den <= den_reg[DEN_W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- hdl/rasmr_checker.sv -----
module rasmr_checker
    import rasmr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // accept makes the unit busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after request");

    // done ends a busy period
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy)) else $error("done outside busy end");

    // denominator never zero
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.res_den != '0) else $error("zero denominator");

    // error result is 0/1
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.div_zero) |-> (rsp.res_num == '0 && rsp.res_den == 1))
        else $error("bad error result");

endmodule

bind rational_add_sub_mul_reduce_unit rasmr_checker u_chk (.*);
